// ===== sv/r2fft_pkg.sv =====
`default_nettype none
package r2fft_pkg;
    localparam int FFT_POINTS = 64;
    localparam int LG = (FFT_POINTS >= 64) ? 6 : (FFT_POINTS >= 32) ? 5 :
                        (FFT_POINTS >= 16) ? 4 : (FFT_POINTS >= 8) ? 3 :
                        (FFT_POINTS >= 4) ? 2 : 1;
    localparam int N = 1 << LG;
    localparam int AW = 6;
    localparam int WW = 40;

    localparam logic [0:0] REG_INVERSE   = 1'b0;
    localparam logic [0:0] REG_NORMALIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD, ST_RD, ST_MUL, ST_ADD, ST_WR, ST_OUT_RD, ST_OUT
    } t_state;

    // butterfly control from sequencer
    typedef struct packed {
        logic          inverse;
        logic [AW-1:0] tw;
    } t_bfly_ctl;

    // cos(2*pi*j/64) * 2^17, j = 0..16
    function automatic logic signed [18:0] qcos(input logic [4:0] j);
        logic signed [18:0] r;
        case (j)
            5'd0:  r = 19'sd131072;  5'd1:  r = 19'sd130441;
            5'd2:  r = 19'sd128553;  5'd3:  r = 19'sd125428;
            5'd4:  r = 19'sd121095;  5'd5:  r = 19'sd115595;
            5'd6:  r = 19'sd108982;  5'd7:  r = 19'sd101320;
            5'd8:  r = 19'sd92682;   5'd9:  r = 19'sd83151;
            5'd10: r = 19'sd72820;   5'd11: r = 19'sd61787;
            5'd12: r = 19'sd50159;   5'd13: r = 19'sd38048;
            5'd14: r = 19'sd25571;   5'd15: r = 19'sd12847;
            default: r = 19'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [18:0] tw_cos(input logic [5:0] t);
        logic signed [18:0] r;
        if (t <= 6'd16)      r = qcos(t[4:0]);
        else if (t <= 6'd32) r = -qcos(5'(6'd32 - t));
        else if (t <= 6'd48) r = -qcos(5'(t - 6'd32));
        else                 r = qcos(5'(7'd64 - {1'b0, t}));
        return r;
    endfunction

    function automatic logic signed [WW-1:0] sat40(input logic signed [WW:0] v);
        logic signed [WW-1:0] r;
        if (v[WW] != v[WW-1]) r = v[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        else r = v[WW-1:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== sv/r2fft_bfly.sv =====
`default_nettype none
module r2fft_bfly import r2fft_pkg::*; (
    input  wire logic                 i_clk,
    input  wire t_bfly_ctl            i_ctl,
    input  wire logic                 i_mul,
    input  wire logic                 i_add,
    input  wire logic signed [WW-1:0] i_ar,
    input  wire logic signed [WW-1:0] i_ai,
    input  wire logic signed [WW-1:0] i_br,
    input  wire logic signed [WW-1:0] i_bi,
    output logic signed [WW-1:0]      o_ar,
    output logic signed [WW-1:0]      o_ai,
    output logic signed [WW-1:0]      o_br,
    output logic signed [WW-1:0]      o_bi
);
    logic signed [18:0] c, s;
    logic signed [59:0] r_pcr, r_psi, r_pci, r_psr;
    logic signed [61:0] xr, xi;
    logic signed [44:0] tr, ti;

    // twiddle lookup, sign follows direction
    always_comb begin
        c = tw_cos(i_ctl.tw);
        s = tw_cos(6'(i_ctl.tw + 6'd48));
        if (!i_ctl.inverse) s = -s;
    end

    // products registered before the sum
    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_pcr <= c * i_br;
            r_psi <= s * i_bi;
            r_pci <= c * i_bi;
            r_psr <= s * i_br;
        end
    end

    // round to Q.8 and combine with sat
    always_comb begin
        xr = 62'(r_pcr) - 62'(r_psi) + 62'sd65536;
        xi = 62'(r_pci) + 62'(r_psr) + 62'sd65536;
        tr = xr[61:17];
        ti = xi[61:17];
    end

    always_ff @(posedge i_clk) begin
        if (i_add) begin
            o_ar <= sat40(41'(i_ar) + 41'(tr));
            o_ai <= sat40(41'(i_ai) + 41'(ti));
            o_br <= sat40(41'(i_ar) - 41'(tr));
            o_bi <= sat40(41'(i_ai) - 41'(ti));
        end
    end
endmodule
`default_nettype wire

// ===== sv/radix2_complex_fft.sv =====
// channel  | direction | ports
// sample   | in        | i_start/o_busy, i_sample_real, i_sample_imag
// bin      | out       | o_valid, o_bin_real, o_bin_imag, o_bin_index, o_last_bin
// config   | in        | i_cfg_we, i_cfg_addr, i_cfg_data
// loading a sample needs an accepted i_start while idle; the last sample starts the transform
// the transform runs (N/2)*log2(N) butterflies, each through RD, MUL, ADD and WR, on one
// shared butterfly and one two-port work memory
// unloading handles each bin in order (memory read, then rounding register)
// busy is high from the last sample until the last bin; reset clears control
// the receiver cannot stall; each bin is shown for one cycle
`default_nettype none
module radix2_complex_fft import r2fft_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [15:0] i_sample_real,
    input  wire logic signed [15:0] i_sample_imag,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_addr,
    input  wire logic               i_cfg_data,
    output logic                    o_valid,
    output logic signed [31:0]      o_bin_real,
    output logic signed [31:0]      o_bin_imag,
    output logic [5:0]              o_bin_index,
    output logic                    o_last_bin
);
    t_state r_state, n_state;
    logic r_inv, r_norm;
    logic [AW-1:0] r_pos, n_pos;
    logic [2:0] r_stage, n_stage;
    logic [AW-1:0] r_k, n_k, r_base, n_base;
    logic [AW-1:0] a_addr, b_addr, half, rev;
    logic signed [WW-1:0] mem_r [0:63];
    logic signed [WW-1:0] mem_i [0:63];
    logic signed [WW-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [WW-1:0] w_ar, w_ai, w_br, w_bi;
    t_bfly_ctl ctl;
    logic accept;
    logic signed [WW:0] rr, ri;
    logic [4:0] sh;
    logic signed [31:0] qr, qi;

    assign accept = i_start && !o_busy;
    assign half = AW'(1) << r_stage;

    // bit-reversed load address
    always_comb begin
        rev = '0;
        for (int i = 0; i < LG; i++) rev[LG-1-i] = r_pos[i];
    end

    assign a_addr = r_base + r_k;
    assign b_addr = a_addr + half;
    assign ctl.inverse = r_inv;
    assign ctl.tw = 6'(r_k << (3'(AW) - 3'd1 - r_stage));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 1'b0;
            r_norm <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_INVERSE:   r_inv <= i_cfg_data;
                REG_NORMALIZE: r_norm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    r2fft_bfly u_bfly (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_mul(r_state == ST_MUL), .i_add(r_state == ST_ADD),
        .i_ar(r_ar), .i_ai(r_ai), .i_br(r_br), .i_bi(r_bi),
        .o_ar(w_ar), .o_ai(w_ai), .o_br(w_br), .o_bi(w_bi)
    );

    // work memory, two ports
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_r[rev] <= {{(WW-24){i_sample_real[15]}}, i_sample_real, 8'd0};
            mem_i[rev] <= {{(WW-24){i_sample_imag[15]}}, i_sample_imag, 8'd0};
        end else if (r_state == ST_WR) begin
            mem_r[a_addr] <= w_ar;
            mem_i[a_addr] <= w_ai;
            mem_r[b_addr] <= w_br;
            mem_i[b_addr] <= w_bi;
        end
        r_ar <= mem_r[a_addr];
        r_ai <= mem_i[a_addr];
        r_br <= mem_r[b_addr];
        r_bi <= mem_i[b_addr];
    end

    // output rounding and saturation
    always_comb begin
        sh = 5'd4 + (r_norm ? 5'(LG) : 5'd0);
        rr = (41'(r_ar) + (41'sd1 <<< (sh - 5'd1))) >>> sh;
        ri = (41'(r_ai) + (41'sd1 <<< (sh - 5'd1))) >>> sh;
        qr = (rr > 41'sd2147483647) ? 32'sh7fffffff :
             (rr < -41'sd2147483648) ? 32'sh80000000 : rr[31:0];
        qi = (ri > 41'sd2147483647) ? 32'sh7fffffff :
             (ri < -41'sd2147483648) ? 32'sh80000000 : ri[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_pos <= '0;
            r_stage <= '0;
            r_k <= '0;
            r_base <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_stage <= n_stage;
            r_k <= n_k;
            r_base <= n_base;
            o_valid <= (r_state == ST_OUT);
        end
        o_bin_real <= qr;
        o_bin_imag <= qi;
        o_bin_index <= r_base;
        o_last_bin <= (r_base == AW'(N - 1));
    end

    // sequencer: stage, twiddle index, group base
    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_stage = r_stage;
        n_k = r_k;
        n_base = r_base;
        o_busy = (r_state != ST_LOAD);
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (r_pos == AW'(N - 1)) begin
                        n_pos = '0;
                        n_stage = '0;
                        n_k = '0;
                        n_base = '0;
                        n_state = ST_RD;
                    end else n_pos = r_pos + 1'b1;
                end
            end
            ST_RD:  n_state = ST_MUL;
            ST_MUL: n_state = ST_ADD;
            ST_ADD: n_state = ST_WR;
            ST_WR: begin
                n_state = ST_RD;
                if (7'(r_base) + 7'(half) + 7'(half) < 7'(N))
                    n_base = r_base + half + half;
                else begin
                    n_base = '0;
                    if (r_k + 1'b1 < half) n_k = r_k + 1'b1;
                    else begin
                        n_k = '0;
                        if (r_stage == 3'(LG - 1)) n_state = ST_OUT_RD;
                        else n_stage = r_stage + 1'b1;
                    end
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (r_base == AW'(N - 1)) begin
                    n_base = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_base = r_base + 1'b1;
                    n_state = ST_OUT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !(r_state == ST_OUT)) else $error("out in load");
    a_valid_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_OUT)) else $error("stray valid");
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_bin) |=> !o_busy) else $error("busy after last");
`endif
endmodule
`default_nettype wire
